### rtl/rdi_pkg.sv
// ----------------------------------------------------------------------------
// rdi_pkg: shared types and constants of the radical inverse unit
// Fixed word field widths and the command/status bundles exchanged between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package rdi_pkg;

	// Fixed field widths of the request and response words
	localparam int INDEX_W = 32;
	localparam int BASE_W  = 8;
	localparam int VALUE_W = 24;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;       // capture a new request word
		logic dig_clr;    // clear the digit remainder before a digit pass
		logic dig_step;   // one restoring step of index / base
		logic accum;      // fold the digit into numerator and denominator
		logic frac_step;  // one restoring step of the fraction division
		logic out_load;   // move the result into the output register
	} rdi_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic idx_zero;   // remaining index is zero, no digits left
		logic bad;        // captured base is below two
	} rdi_stat_t;

endpackage

### rtl/rdi_req_if.sv
// ----------------------------------------------------------------------------
// rdi_req_if: request channel of the radical inverse unit
// Carries index and base with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rdi_req_if
	import rdi_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] index;
	logic [BASE_W-1:0]  base;

	modport source (output valid, output index, output base, input ready);
	modport sink   (input valid, input index, input base, output ready);
endinterface

### rtl/rdi_rsp_if.sv
// ----------------------------------------------------------------------------
// rdi_rsp_if: response channel of the radical inverse unit
// Carries the fixed-point value and the bad base flag with valid/ready.
// ----------------------------------------------------------------------------
interface rdi_rsp_if
	import rdi_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               bad_base;

	modport source (output valid, output value, output bad_base, input ready);
	modport sink   (input valid, input value, input bad_base, output ready);
endinterface

### rtl/rdi_datapath.sv
// ----------------------------------------------------------------------------
// rdi_datapath: arithmetic of the radical inverse unit
// Bit-serial index / base division for digit extraction, a multiply-add that
// builds the reversed numerator and the power denominator, a bit-serial
// restoring fraction division and the output register.
// ----------------------------------------------------------------------------
module rdi_datapath
	import rdi_pkg::*;
#(
	parameter int FRAC_BITS  = 24,
	parameter int INDEX_BITS = 32
) (
	input  logic               clk,
	input  rdi_cmd_t           cmd,
	output rdi_stat_t          stat,
	input  logic [INDEX_W-1:0] req_index,
	input  logic [BASE_W-1:0]  req_base,
	output logic [VALUE_W-1:0] value,
	output logic               bad_base
);

	// Numerator and denominator stay below 2^INDEX_BITS * 2^BASE_W
	localparam int DW = INDEX_BITS + BASE_W;

	logic [INDEX_BITS-1:0] idx_q;
	logic [BASE_W-1:0]     base_q;
	logic                  bad_q;
	logic [BASE_W-1:0]     dig_q;
	logic [DW-1:0]         num_q;
	logic [DW-1:0]         den_q;
	logic [FRAC_BITS-1:0]  quo_q;
	logic [VALUE_W-1:0]    value_q;
	logic                  bad_out_q;

	logic [BASE_W:0]   dig_trial;
	logic              dig_ge;
	logic [DW+BASE_W-1:0] num_prod;
	logic [DW+BASE_W-1:0] den_prod;
	logic [DW:0]       frac_trial;
	logic              frac_ge;

	// Trial subtract of the base from the shifted digit remainder
	always_comb begin
		dig_trial = {dig_q, idx_q[INDEX_BITS-1]};
		dig_ge    = dig_trial >= {1'b0, base_q};
	end

	// Multiply-add for the reversed numerator and the power of the base
	always_comb begin
		num_prod = (DW+BASE_W)'(num_q) * (DW+BASE_W)'(base_q)
			+ (DW+BASE_W)'(dig_q);
		den_prod = (DW+BASE_W)'(den_q) * (DW+BASE_W)'(base_q);
	end

	// Trial subtract of the denominator from the doubled fraction remainder
	always_comb begin
		frac_trial = {num_q, 1'b0};
		frac_ge    = frac_trial >= {1'b0, den_q};
	end

	// Advance the working registers as commanded
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q  <= req_index[INDEX_BITS-1:0];
			base_q <= req_base;
			bad_q  <= (req_base < BASE_W'(2));
			num_q  <= '0;
			den_q  <= DW'(1);
			quo_q  <= '0;
		end else if (cmd.dig_clr) begin
			dig_q <= '0;
		end else if (cmd.dig_step) begin
			dig_q <= dig_ge ? BASE_W'(dig_trial - {1'b0, base_q}) : dig_trial[BASE_W-1:0];
			idx_q <= {idx_q[INDEX_BITS-2:0], dig_ge};
		end else if (cmd.accum) begin
			num_q <= num_prod[DW-1:0];
			den_q <= den_prod[DW-1:0];
		end else if (cmd.frac_step) begin
			num_q <= frac_ge ? DW'(frac_trial - {1'b0, den_q}) : frac_trial[DW-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], frac_ge};
		end
	end

	// Hold the finished word in the output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value_q   <= VALUE_W'(quo_q);
			bad_out_q <= bad_q;
		end
	end

	assign stat.idx_zero = (idx_q == '0);
	assign stat.bad      = bad_q;
	assign value         = value_q;
	assign bad_base      = bad_out_q;

endmodule

### rtl/rdi_ctrl.sv
// ----------------------------------------------------------------------------
// rdi_ctrl: sequencer of the radical inverse unit
// Steps the datapath through digit passes, the fraction division and the
// output hand-off, and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module rdi_ctrl
	import rdi_pkg::*;
#(
	parameter int FRAC_BITS  = 24,
	parameter int INDEX_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rdi_cmd_t  cmd,
	input  rdi_stat_t stat
);

	localparam int MAX_STEPS = (INDEX_BITS > FRAC_BITS) ? INDEX_BITS : FRAC_BITS;
	localparam int CNT_W     = $clog2(MAX_STEPS);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_DIGIT = 6'b000100,
		ST_ACCUM = 6'b001000,
		ST_FRAC  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             rsp_valid_q;
	logic             out_free;

	assign out_free = !rsp_valid_q || rsp_ready;

	// Decode the next state, the step count and the datapath commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cnt_d = '0;
				if (stat.bad) begin
					state_d = ST_DONE;
				end else if (stat.idx_zero) begin
					state_d = ST_FRAC;
				end else begin
					cmd.dig_clr = 1'b1;
					state_d     = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				cmd.dig_step = 1'b1;
				if (cnt_q == CNT_W'(INDEX_BITS - 1)) begin
					state_d = ST_ACCUM;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_FRAC: begin
				cmd.frac_step = 1'b1;
				if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Hold the response valid until the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

### rtl/radical_inverse_unit.sv
// Radical inverse unit: returns floor(N * 2^FRAC_BITS / base^k) for each request word,
// where N is the low INDEX_BITS bits of index with its k base-b digits mirrored,
// truncated to the 24-bit value field; index zero gives zero, and a base below
// two gives zero with bad_base set. One word is worked at a time. A word with
// k digits runs k digit passes and then the fraction division; index zero
// skips the digit passes and a bad base skips both. Each digit is split off
// by a one-bit-per-cycle division of the index by the base, and the final
// fraction is one bit per cycle from a restoring divider. The output
// register lets the next word be accepted while a response waits.
// ----------------------------------------------------------------------------
// radical_inverse_unit: Halton radical inverse, top level
// Joins the sequencer and the datapath to the request and response channels.
// ----------------------------------------------------------------------------
module radical_inverse_unit
	import rdi_pkg::*;
#(
	parameter int FRAC_BITS  = 24,
	parameter int INDEX_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	rdi_req_if.sink      req,
	rdi_rsp_if.source    rsp
);

	rdi_cmd_t  cmd;
	rdi_stat_t stat;

	// Sequence the work of one word
	rdi_ctrl #(
		.FRAC_BITS  (FRAC_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Digit extraction, accumulation and fraction division
	rdi_datapath #(
		.FRAC_BITS  (FRAC_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.stat      (stat),
		.req_index (req.index),
		.req_base  (req.base),
		.value     (rsp.value),
		.bad_base  (rsp.bad_base)
	);

`ifndef ASSERT_OFF
	// A bad base word always carries a zero value
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.bad_base |-> rsp.value == '0)
		else $error("bad base response with nonzero value");

	// One word at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while a word is in work");

	// The output register is loaded only when free
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !rsp.valid || rsp.ready)
		else $error("response overwritten before it was taken");
`endif

endmodule
